// ----- rtl/core/srtf_pkg.sv -----
// Shared types and constants for the SRTF scheduler.
// Used by srtf_mem, srtf_scan and srtf_scheduler; no dependencies.
package srtf_pkg;

    localparam int unsigned ARR_W     = 16;   // arrival tick
    localparam int unsigned BURST_W   = 16;   // burst / remaining ticks
    localparam int unsigned IDX_OUT_W = 4;    // proc_index port
    localparam int unsigned TICK_W    = 21;   // finish_tick, turnaround ports
    localparam int unsigned WAIT_W    = 20;   // wait_ticks port

    // One process table entry
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
    } mem_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT_SCAN,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/core/srtf_mem.sv -----
// Process table RAM: one write port, one read port, registered read data.
// Depends on srtf_pkg (mem_entry_t).
module srtf_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  srtf_pkg::mem_entry_t wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output srtf_pkg::mem_entry_t rdata
);
    import srtf_pkg::*;

    mem_entry_t ram [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= ram[raddr];
        end
    end

endmodule

// ----- rtl/core/srtf_scan.sv -----
// Table scan unit: consumes one entry per cycle and keeps the best ready
// process, the next future arrival and the minimum arrival. Depends on srtf_pkg.
module srtf_scan #(
    parameter int unsigned AW      = 4,
    parameter int unsigned CLOCK_W = 21
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        valid,
    input  logic [AW-1:0]               idx,
    input  srtf_pkg::mem_entry_t        entry,
    input  logic                        finished,
    input  logic [CLOCK_W-1:0]          clock_now,
    output logic                        found,
    output logic [AW-1:0]               best_idx,
    output srtf_pkg::mem_entry_t        best_entry,
    output logic                        more,
    output logic [srtf_pkg::ARR_W-1:0]  next_arrival,
    output logic [srtf_pkg::ARR_W-1:0]  min_arrival
);
    import srtf_pkg::*;

    logic             found_reg;
    logic             more_reg;
    logic [AW-1:0]    best_idx_reg;
    mem_entry_t       best_reg;
    logic [ARR_W-1:0] nxt_reg;
    logic [ARR_W-1:0] min_reg;

    logic is_ready;
    logic is_later;
    logic better;
    logic take_best;
    logic take_nxt;

    always_comb
    begin
        is_ready = valid && !finished && (CLOCK_W'(entry.arrival) <= clock_now);
        is_later = valid && !finished && (CLOCK_W'(entry.arrival) > clock_now);
        // strict compares keep the lowest index on a full tie
        better = !found_reg
              || (entry.remaining < best_reg.remaining)
              || ((entry.remaining == best_reg.remaining)
                  && (entry.arrival < best_reg.arrival));
        take_best = is_ready && better;
        take_nxt  = is_later && (!more_reg || (entry.arrival < nxt_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            more_reg  <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
            more_reg  <= 1'b0;
        end
        else
        begin
            if (take_best)
            begin
                found_reg <= 1'b1;
            end
            if (take_nxt)
            begin
                more_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            min_reg <= '1;
        end
        else
        begin
            if (take_best)
            begin
                best_idx_reg <= idx;
                best_reg     <= entry;
            end
            if (take_nxt)
            begin
                nxt_reg <= entry.arrival;
            end
            if (valid && (entry.arrival < min_reg))
            begin
                min_reg <= entry.arrival;
            end
        end
    end

    assign found        = found_reg;
    assign more         = more_reg;
    assign best_idx     = best_idx_reg;
    assign best_entry   = best_reg;
    assign next_arrival = nxt_reg;
    assign min_arrival  = min_reg;

endmodule

// ----- rtl/core/srtf_scheduler.sv -----
// Preemptive SRTF scheduler. Loading: one process transaction per cycle while in the load state.
// Simulation: a start-time scan, then each scheduling decision costs one table scan plus
// one decide state; each completion passes through a result state, then offers the result
// until it is taken. Results leave in completion order.
// Reset clears all control state and finish marks; the table RAM is not reset.
module srtf_scheduler #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // process load channel
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [srtf_pkg::ARR_W-1:0]        arrival_tick,
    input  logic [srtf_pkg::BURST_W-1:0]      burst_ticks,
    input  logic                              final_process,
    // completion result channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [srtf_pkg::IDX_OUT_W-1:0]    proc_index,
    output logic [srtf_pkg::TICK_W-1:0]       finish_tick,
    output logic [srtf_pkg::TICK_W-1:0]       turnaround,
    output logic [srtf_pkg::WAIT_W-1:0]       wait_ticks,
    output logic                              final_result
);
    import srtf_pkg::*;

    localparam int unsigned AW        = $clog2(MAX_PROCS);
    localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);
    // latest possible time: max arrival plus every burst back to back
    localparam int unsigned CLOCK_W   = ARR_W + CNT_W;
    localparam int unsigned EXT_W     = (CLOCK_W > TICK_W) ? CLOCK_W : TICK_W;
    localparam int unsigned IDX_EXT_W = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     loaded_reg;     // processes in the table
    logic [CNT_W-1:0]     done_reg;       // processes finished
    logic [CNT_W-1:0]     issue_reg;      // scan read pointer
    logic                 rd_valid_reg;   // RAM read data valid this cycle
    logic [AW-1:0]        rd_idx_reg;
    logic [MAX_PROCS-1:0] fin_reg;        // finish marks, one flop per entry
    logic [CLOCK_W-1:0]   clock_reg;      // simulated time

    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [TICK_W-1:0]    out_finish_reg;
    logic [TICK_W-1:0]    out_tat_reg;
    logic [WAIT_W-1:0]    out_wait_reg;
    logic                 out_final_reg;

    // RAM ports
    logic       mem_we;
    logic [AW-1:0] mem_waddr;
    mem_entry_t mem_wdata;
    logic       mem_re;
    mem_entry_t mem_rdata;

    // scan results
    logic             sc_found;
    logic [AW-1:0]    sc_best_idx;
    mem_entry_t       sc_best;
    logic             sc_more;
    logic [ARR_W-1:0] sc_next_arr;
    logic [ARR_W-1:0] sc_min_arr;

    logic                 item_acc;
    logic                 room;
    logic                 scan_state;
    logic                 issue_more;
    logic                 scan_end;
    logic                 scan_clear;
    logic [CLOCK_W-1:0]   gap;
    logic                 preempt;
    logic                 run_done;
    logic                 teardown;
    logic [EXT_W-1:0]     clock_ext;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [EXT_W-1:0]     tat_ext;
    logic [EXT_W-1:0]     wait_ext;

    srtf_mem #(
        .DEPTH (MAX_PROCS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (issue_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    srtf_scan #(
        .AW      (AW),
        .CLOCK_W (CLOCK_W)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (scan_clear),
        .valid        (rd_valid_reg),
        .idx          (rd_idx_reg),
        .entry        (mem_rdata),
        .finished     (fin_reg[rd_idx_reg]),
        .clock_now    (clock_reg),
        .found        (sc_found),
        .best_idx     (sc_best_idx),
        .best_entry   (sc_best),
        .more         (sc_more),
        .next_arrival (sc_next_arr),
        .min_arrival  (sc_min_arr)
    );

    always_comb
    begin
        item_ready = (state_reg == ST_LOAD);
        item_acc   = item_valid && item_ready;
        room       = (loaded_reg < CNT_W'(MAX_PROCS));

        scan_state = (state_reg == ST_INIT_SCAN) || (state_reg == ST_SCAN);
        issue_more = (issue_reg < loaded_reg);
        mem_re     = scan_state && issue_more;
        // last read data has been folded into the scan registers
        scan_end   = scan_state && !issue_more && !rd_valid_reg;
        scan_clear = scan_state && (issue_reg == '0);

        // run the chosen process until it finishes or the next arrival
        gap      = CLOCK_W'(sc_next_arr) - clock_reg;
        preempt  = sc_more && (gap < CLOCK_W'(sc_best.remaining));
        run_done = (state_reg == ST_DECIDE) && sc_found && !preempt;

        // table write: load, or remaining-time writeback after a decision
        mem_we    = 1'b0;
        mem_waddr = loaded_reg[AW-1:0];
        mem_wdata = '{arrival: arrival_tick, burst: burst_ticks, remaining: burst_ticks};
        if (item_acc && room)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == ST_DECIDE) && sc_found)
        begin
            mem_we    = 1'b1;
            mem_waddr = sc_best_idx;
            mem_wdata = sc_best;
            mem_wdata.remaining = preempt ? (sc_best.remaining - gap[BURST_W-1:0]) : '0;
        end

        clock_ext = EXT_W'(clock_reg);
        idx_ext   = IDX_EXT_W'(sc_best_idx);
        tat_ext   = clock_ext - EXT_W'(sc_best.arrival);
        wait_ext  = tat_ext - EXT_W'(sc_best.burst);

        teardown = ((state_reg == ST_DECIDE) && !sc_found && !sc_more)
                || ((state_reg == ST_EMIT) && result_ready && out_final_reg);

        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_acc && final_process)
                begin
                    state_next = ST_INIT_SCAN;
                end
            end
            ST_INIT_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!sc_found)
                begin
                    state_next = sc_more ? ST_SCAN : ST_LOAD;
                end
                else
                begin
                    state_next = preempt ? ST_SCAN : ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (result_ready)
                begin
                    state_next = out_final_reg ? ST_LOAD : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control counters, finish marks and simulated time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            done_reg     <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fin_reg      <= '0;
            clock_reg    <= '0;
        end
        else
        begin
            rd_valid_reg <= mem_re;

            if (mem_re)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            else if (scan_end)
            begin
                issue_reg <= '0;
            end

            if (item_acc && room)
            begin
                loaded_reg <= loaded_reg + 1'b1;
            end

            if ((state_reg == ST_INIT_SCAN) && scan_end)
            begin
                clock_reg <= CLOCK_W'(sc_min_arr);
            end

            if (state_reg == ST_DECIDE)
            begin
                if ((!sc_found && sc_more) || (sc_found && preempt))
                begin
                    clock_reg <= CLOCK_W'(sc_next_arr);
                end
                else if (sc_found)
                begin
                    clock_reg <= clock_reg + CLOCK_W'(sc_best.remaining);
                end
            end

            if (run_done)
            begin
                fin_reg[sc_best_idx] <= 1'b1;
                done_reg             <= done_reg + 1'b1;
            end

            if (teardown)
            begin
                loaded_reg <= '0;
                done_reg   <= '0;
                fin_reg    <= '0;
            end
        end
    end

    // read pointer pipeline and result register
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= issue_reg[AW-1:0];
        if (state_reg == ST_RESULT)
        begin
            out_idx_reg    <= idx_ext[IDX_OUT_W-1:0];
            out_finish_reg <= clock_ext[TICK_W-1:0];
            out_tat_reg    <= tat_ext[TICK_W-1:0];
            out_wait_reg   <= wait_ext[WAIT_W-1:0];
            out_final_reg  <= (done_reg == loaded_reg);
        end
    end

    assign result_valid = (state_reg == ST_EMIT);
    assign proc_index   = out_idx_reg;
    assign finish_tick  = out_finish_reg;
    assign turnaround   = out_tat_reg;
    assign wait_ticks   = out_wait_reg;
    assign final_result = out_final_reg;

endmodule

// ----- sim/srtf_scheduler_tb.sv -----
// Self-checking testbench for srtf_scheduler: a directed table of process sets, then
// random sets; every completion compared with hand-computed values or an in-bench
// SRTF predictor. Depends on srtf_pkg and the srtf_scheduler RTL.
module srtf_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srtf_pkg::*;

    localparam int unsigned PROCS        = 16;
    localparam int unsigned RANDOM_LOADS = 304;
    // quiet cycles after the last expected completion; catches stray results
    localparam int unsigned DRAIN_CYCLES = 200;

    // One completion transaction as seen on the result channel
    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [TICK_W-1:0]    finish;
        logic [TICK_W-1:0]    tat;
        logic [WAIT_W-1:0]    waited;
        logic                 last;
    } completion_t;

    // One process load; typed rows carry a hand-computed completion
    typedef struct {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               closes_set;
        logic               typed;
        completion_t        want;
    } proc_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 item_valid    = 1'b0;
    logic                 item_ready;
    logic [ARR_W-1:0]     arrival_tick  = '0;
    logic [BURST_W-1:0]   burst_ticks   = '0;
    logic                 final_process = 1'b0;
    logic                 result_valid;
    logic                 result_ready  = 1'b0;
    logic [IDX_OUT_W-1:0] proc_index;
    logic [TICK_W-1:0]    finish_tick;
    logic [TICK_W-1:0]    turnaround;
    logic [WAIT_W-1:0]    wait_ticks;
    logic                 final_result;

    // Predictor state: process table, finish marks and the scheduling clock
    int unsigned sched_arrival [PROCS];
    int unsigned sched_burst   [PROCS];
    int unsigned sched_left    [PROCS];
    bit          sched_done    [PROCS];
    int unsigned sched_count = 0;
    int unsigned sched_now   = 0;

    completion_t fresh_done[$];       // completions of the set just closed
    completion_t completions_due[$];  // completions not yet seen on the port
    proc_row_t   stim_rows[$];        // rows of the set being sent

    int unsigned     errors        = 0;
    int unsigned     checked       = 0;
    int unsigned     loads_kept    = 0;
    int unsigned     loads_dropped = 0;
    int unsigned     sets_run      = 0;
    bit              steady_phase  = 1'b0;
    longint unsigned cycle_limit   = 20000;
    longint unsigned cycle_count   = 0;

    always #10 clk = ~clk;

    srtf_scheduler #(
        .MAX_PROCS (PROCS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .arrival_tick  (arrival_tick),
        .burst_ticks   (burst_ticks),
        .final_process (final_process),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .proc_index    (proc_index),
        .finish_tick   (finish_tick),
        .turnaround    (turnaround),
        .wait_ticks    (wait_ticks),
        .final_result  (final_result)
    );

    // ------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------

    function automatic void add_fresh(input completion_t c);
        fresh_done = {fresh_done, c};
    endfunction

    function automatic void add_due(input completion_t c);
        completions_due = {completions_due, c};
    endfunction

    function automatic void add_row(input proc_row_t r);
        stim_rows = {stim_rows, r};
    endfunction

    // ------------------------------------------------------------------
    // SRTF predictor
    // ------------------------------------------------------------------

    // Ready process with least remaining time; ties go to earlier arrival,
    // then lower index (strict compare keeps the first one found).
    function automatic int pick_shortest();
        int best;
        int i;
        best = -1;
        for (i = 0; i < sched_count; i++) begin
            if (sched_done[i] || sched_arrival[i] > sched_now)
                continue;
            if (best < 0 || sched_left[i] < sched_left[best] ||
                (sched_left[i] == sched_left[best] &&
                 sched_arrival[i] < sched_arrival[best]))
                best = i;
        end
        return best;
    endfunction

    // Earliest arrival still in the future among unfinished processes
    function automatic bit next_arrival(output int unsigned when);
        bit found;
        int i;
        found = 1'b0;
        when  = 0;
        for (i = 0; i < sched_count; i++) begin
            if (sched_done[i] || sched_arrival[i] <= sched_now)
                continue;
            if (!found || sched_arrival[i] < when) begin
                when  = sched_arrival[i];
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Runs the loaded set to completion, queueing completions into fresh_done.
    // A process runs until it finishes or the next arrival can preempt it.
    function automatic void run_srtf_set();
        int          sel;
        int          i;
        int unsigned nxt;
        int unsigned run;
        int unsigned tat;
        int unsigned waited;
        int unsigned finished_n;
        bit          more;
        completion_t c;
        finished_n = 0;
        sched_now  = 32'hFFFF_FFFF;
        for (i = 0; i < sched_count; i++)
            if (sched_arrival[i] < sched_now)
                sched_now = sched_arrival[i];
        while (finished_n < sched_count) begin
            sel  = pick_shortest();
            more = next_arrival(nxt);
            if (sel < 0) begin
                // nobody ready: jump to the next arrival
                if (!more)
                    break;
                sched_now = nxt;
                continue;
            end
            run = sched_left[sel];
            if (more && nxt - sched_now < run)
                run = nxt - sched_now;
            sched_left[sel] -= run;
            sched_now += run;
            if (sched_left[sel] == 0) begin
                sched_done[sel] = 1'b1;
                finished_n++;
                tat      = sched_now - sched_arrival[sel];
                waited   = tat - sched_burst[sel];
                c.idx    = sel[IDX_OUT_W-1:0];
                c.finish = sched_now[TICK_W-1:0];
                c.tat    = tat[TICK_W-1:0];
                c.waited = waited[WAIT_W-1:0];
                c.last   = (finished_n == sched_count);
                add_fresh(c);
            end
        end
        sched_count = 0;
        for (i = 0; i < PROCS; i++)
            sched_done[i] = 1'b0;
    endfunction

    // Applies one accepted load; returns 0 when the table was full
    function automatic bit load_process(input int unsigned arr, input int unsigned burst,
                                        input bit closes);
        bit kept;
        kept = (sched_count < PROCS);
        fresh_done.delete();
        if (kept) begin
            sched_arrival[sched_count] = arr;
            sched_burst[sched_count]   = burst;
            sched_left[sched_count]    = burst;
            sched_done[sched_count]    = 1'b0;
            sched_count++;
        end
        if (closes)
            run_srtf_set();
        return kept;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic proc_row_t row_of(input int unsigned arr, input int unsigned burst,
                                         input bit closes);
        proc_row_t r;
        r.arrival    = arr[ARR_W-1:0];
        r.burst      = burst[BURST_W-1:0];
        r.closes_set = closes;
        r.typed      = 1'b0;
        r.want       = '0;
        return r;
    endfunction

    // Single-process set whose completion is obvious by hand
    function automatic proc_row_t row_known(input int unsigned arr, input int unsigned burst,
                                            input int unsigned fin, input int unsigned tat,
                                            input int unsigned waited);
        proc_row_t r;
        r             = row_of(arr, burst, 1'b1);
        r.typed       = 1'b1;
        r.want.idx    = '0;
        r.want.finish = fin[TICK_W-1:0];
        r.want.tat    = tat[TICK_W-1:0];
        r.want.waited = waited[WAIT_W-1:0];
        r.want.last   = 1'b1;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drives one load transaction; returns at the edge where it is taken.
    // Handshake is sampled at the falling edge, where everything is settled.
    task automatic send_process(input proc_row_t row);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        arrival_tick  <= row.arrival;
        burst_ticks   <= row.burst;
        final_process <= row.closes_set;
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        if (load_process(32'(row.arrival), 32'(row.burst), row.closes_set))
            loads_kept++;
        else
            loads_dropped++;
        if (row.closes_set)
            sets_run++;
        if (row.typed)
            add_due(row.want);
        else
            foreach (fresh_done[k])
                add_due(fresh_done[k]);
        // budget per load: a few table scans, one result stall and one idle gap
        cycle_limit += 4 * (3 * (PROCS + 4) + 2 * 64);
        @(posedge clk);
    endtask

    function automatic void cmp_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and checking
    // ------------------------------------------------------------------

    initial begin : result_sink
        int unsigned run_len;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            run_len = $urandom_range(1, 24);
            result_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            run_len = idle_cycles();
            if (run_len > 0) begin
                result_ready <= 1'b0;
                repeat (run_len) @(posedge clk);
            end
        end
    end

    // A completion seen here is the transaction taken at the next rising edge
    always @(negedge clk) begin : completion_check
        completion_t want;
        if (rst_n && result_valid && result_ready) begin
            if (completions_due.size() == 0) begin
                $display("%0t: unexpected completion proc_index %0d finish_tick %0d",
                         $time, proc_index, finish_tick);
                errors++;
            end else begin
                want = completions_due.pop_front();
                checked++;
                cmp_field("proc_index",   32'(want.idx),    32'(proc_index));
                cmp_field("finish_tick",  32'(want.finish), 32'(finish_tick));
                cmp_field("turnaround",   32'(want.tat),    32'(turnaround));
                cmp_field("wait_ticks",   32'(want.waited), 32'(wait_ticks));
                cmp_field("final_result", 32'(want.last),   32'(final_result));
            end
        end
    end

    // Hang guard; the limit grows with every accepted load
    initial begin : watchdog
        while (cycle_count < cycle_limit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d completions outstanding",
                 $time, cycle_count, completions_due.size());
        $display("srtf_scheduler: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int unsigned i;
        int unsigned n;
        int unsigned kind;
        int unsigned base;
        int unsigned span;
        int unsigned arr;
        int unsigned burst;
        int unsigned start_sent;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        // after reset: one single-tick process at time zero
        add_row(row_known(0, 1, 1, 1, 0));
        // largest arrival and burst together
        add_row(row_known(16'hFFFF, 16'hFFFF, 131070, 65535, 0));
        // zero burst on its own finishes at its arrival
        add_row(row_known(100, 0, 100, 0, 0));
        // preemption, equal remaining and arrival (lower index wins),
        // zero burst mid-run, then an idle gap up to the last arrival
        add_row(row_of(10, 8, 1'b0));
        add_row(row_of(12, 3, 1'b0));
        add_row(row_of(12, 3, 1'b0));
        add_row(row_of(11, 0, 1'b0));
        add_row(row_of(60, 5, 1'b1));
        // full table; one plain load and the closing load both get dropped
        for (i = 0; i < PROCS; i++)
            add_row(row_of((i * 5) % 23, 1 + (i * 7) % 13, 1'b0));
        add_row(row_of(5, 4, 1'b0));
        add_row(row_of(7, 9, 1'b1));
        foreach (stim_rows[k])
            send_process(stim_rows[k]);

        // Random sets, mostly dense contention with small bursts
        start_sent = loads_kept + loads_dropped;
        while (loads_kept + loads_dropped - start_sent < RANDOM_LOADS) begin
            stim_rows.delete();
            steady_phase = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 11);
            if (kind == 0) begin
                // full-range values, kept to tiny sets since long bursts are slow
                n = $urandom_range(1, 2);
                for (i = 0; i < n; i++)
                    add_row(row_of($urandom_range(0, 65535),
                                   $urandom_range(0, 65535), 1'b0));
            end else if (kind == 1) begin
                // overfull: the extra loads must be ignored
                n = $urandom_range(PROCS + 1, PROCS + 2);
                for (i = 0; i < n; i++)
                    add_row(row_of($urandom_range(0, 50),
                                   $urandom_range(1, 12), 1'b0));
            end else begin
                n    = $urandom_range(1, PROCS);
                base = $urandom_range(0, 65000);
                span = $urandom_range(0, 1) ? 8 : 200;
                for (i = 0; i < n; i++) begin
                    arr   = base + $urandom_range(0, span);
                    burst = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40);
                    // copy the previous process now and then to force ties
                    if (i > 0 && $urandom_range(0, 7) == 0) begin
                        arr   = 32'(stim_rows[i-1].arrival);
                        burst = 32'(stim_rows[i-1].burst);
                    end
                    add_row(row_of(arr, burst, 1'b0));
                end
            end
            stim_rows[n-1].closes_set = 1'b1;
            foreach (stim_rows[k])
                send_process(stim_rows[k]);
        end
        item_valid    <= 1'b0;
        final_process <= 1'b0;

        while (completions_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d process sets: %0d loads taken, %0d dropped on a full table.",
                 sets_run, loads_kept, loads_dropped);
        $display("Checked %0d completions under random gaps on both channels.", checked);
        if (errors == 0)
            $display("srtf_scheduler: match");
        else
            $display("srtf_scheduler: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/srtf_pkg.sv
rtl/core/srtf_mem.sv
rtl/core/srtf_scan.sv
rtl/core/srtf_scheduler.sv
sim/srtf_scheduler_tb.sv
